// ----- hw/rtl/kmcr_pkg.sv -----
// ----------------------------------------------------------------------------
// kmcr_pkg
// Shared types, constants and helpers for the keyboard and mouse controller
// register block.
// ----------------------------------------------------------------------------
package kmcr_pkg;

   // Ring depth of the keyboard and mouse byte queues. One slot stays empty.
   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   // Register offsets.
   localparam logic [7:0] REG_POWER      = 8'h01;
   localparam logic [7:0] REG_RESET      = 8'h02;
   localparam logic [7:0] REG_NMI        = 8'h03;
   localparam logic [7:0] REG_LED        = 8'h05;
   localparam logic [7:0] REG_KEY_DATA   = 8'h07;
   localparam logic [7:0] REG_MOUSE_MODE = 8'h20;
   localparam logic [7:0] REG_MOUSE_DATA = 8'h21;
   localparam logic [7:0] REG_MOUSE_ID   = 8'h22;

   localparam logic [7:0] KEY_PREFIX_PRESS   = 8'h7f;
   localparam logic [7:0] KEY_PREFIX_RELEASE = 8'hff;
   localparam logic [7:0] KEY_RELEASE_BIT    = 8'b1000_0000;
   localparam logic [7:0] REG_UNMAPPED       = 8'hff;

   localparam logic [1:0] MOUSE_ID_WHEEL   = 2'd3;
   localparam logic [1:0] MOUSE_ID_BASIC   = 2'd0;
   localparam logic [7:0] MOUSE_ID_ALIAS   = 8'd4;

   localparam logic signed [15:0] MOVE_MAX = 16'sd255;
   localparam logic signed [15:0] MOVE_MIN = -16'sd256;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_KEY   = 2'd2,
      OP_MOUSE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MB_FLAG  = 2'd0,
      MB_X     = 2'd1,
      MB_Y     = 2'd2,
      MB_WHEEL = 2'd3
   } mouse_byte_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_KEY_CODE,
      ST_MOUSE_CHECK,
      ST_MOUSE_FLAG,
      ST_MOUSE_X,
      ST_MOUSE_Y,
      ST_MOUSE_WHEEL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic           load_item;
      logic           exec_reg;
      logic           key_push;
      logic           key_prefix;
      logic           mouse_push;
      mouse_byte_type mouse_sel;
      logic           mouse_advance;
      logic           load_rsp;
   } kmcr_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       key_extended;
      logic       mouse_room;
      logic       packet4;
      logic       last_packet;
   } kmcr_status_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] fifo_count(input logic [PTR_W-1:0] head,
                                                   input logic [PTR_W-1:0] tail);
      logic [CNT_W-1:0] h;
      logic [CNT_W-1:0] t;
      h = {1'b0, head};
      t = {1'b0, tail};
      return (h >= t) ? h - t : h + CNT_W'(FIFO_DEPTH) - t;
   endfunction

endpackage

// ----- hw/rtl/kmcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// kmcr_ctrl
// Sequencer for one item at a time: dispatches register accesses, key pushes
// and the per-packet mouse loop, then hands the result to the output register.
// ----------------------------------------------------------------------------
module kmcr_ctrl
   import kmcr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output kmcr_cmd_type    cmd,
   input  kmcr_status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (status.opcode)
               OP_READ, OP_WRITE: begin
                  cmd.exec_reg = 1'b1;
                  state_in     = ST_FINISH;
               end
               OP_KEY: begin
                  cmd.key_push   = 1'b1;
                  cmd.key_prefix = status.key_extended;
                  state_in       = status.key_extended ? ST_KEY_CODE : ST_FINISH;
               end
               OP_MOUSE: begin
                  state_in = ST_MOUSE_CHECK;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_KEY_CODE: begin
            cmd.key_push = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_MOUSE_CHECK: begin
            if (status.mouse_room) begin
               state_in = ST_MOUSE_FLAG;
            end else begin
               // The packet is dropped whole; the movement is still consumed.
               cmd.mouse_advance = 1'b1;
               state_in          = status.last_packet ? ST_FINISH : ST_MOUSE_CHECK;
            end
         end
         ST_MOUSE_FLAG: begin
            cmd.mouse_push = 1'b1;
            cmd.mouse_sel  = MB_FLAG;
            state_in       = ST_MOUSE_X;
         end
         ST_MOUSE_X: begin
            cmd.mouse_push = 1'b1;
            cmd.mouse_sel  = MB_X;
            state_in       = ST_MOUSE_Y;
         end
         ST_MOUSE_Y: begin
            cmd.mouse_push = 1'b1;
            cmd.mouse_sel  = MB_Y;
            if (status.packet4) begin
               state_in = ST_MOUSE_WHEEL;
            end else begin
               cmd.mouse_advance = 1'b1;
               state_in          = status.last_packet ? ST_FINISH : ST_MOUSE_CHECK;
            end
         end
         ST_MOUSE_WHEEL: begin
            cmd.mouse_push    = 1'b1;
            cmd.mouse_sel     = MB_WHEEL;
            cmd.mouse_advance = 1'b1;
            state_in          = status.last_packet ? ST_FINISH : ST_MOUSE_CHECK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("result load did not raise the output valid");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter dispatch");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.exec_reg, cmd.key_push, cmd.mouse_push, cmd.load_rsp}))
      else $error("more than one datapath action in a cycle");

   a_packet_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOUSE_X) |-> ($past(state_ff) == ST_MOUSE_FLAG))
      else $error("mouse X byte not preceded by the flag byte");

endmodule

// ----- hw/rtl/kmcr_dp.sv -----
// ----------------------------------------------------------------------------
// kmcr_dp
// Datapath: item registers, keyboard and mouse byte queues, controller
// registers and the result register.
// ----------------------------------------------------------------------------
module kmcr_dp
   import kmcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  kmcr_cmd_type          cmd,
   output kmcr_status_type       status
);

   // Item registers.
   opcode_type         op_ff, op_in;
   logic [7:0]         addr_ff, addr_in;
   logic [7:0]         wdata_ff, wdata_in;
   logic [6:0]         code_ff, code_in;
   logic               ext_ff, ext_in;
   logic               down_ff, down_in;
   logic signed [15:0] mx_ff, mx_in;
   logic signed [15:0] my_ff, my_in;
   logic [2:0]         btn_ff, btn_in;
   logic [7:0]         wheel_ff, wheel_in;
   logic [7:0]         rd_ff, rd_in;
   logic               pulse_ff, pulse_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   // Controller state.
   logic [PTR_W-1:0]   key_head_ff, key_head_in;
   logic [PTR_W-1:0]   key_tail_ff, key_tail_in;
   logic [PTR_W-1:0]   mouse_head_ff, mouse_head_in;
   logic [PTR_W-1:0]   mouse_tail_ff, mouse_tail_in;
   logic [1:0]         mode_ff, mode_in;
   logic [1:0]         pos_ff, pos_in;
   logic               reset_flag_ff, reset_flag_in;
   logic               nmi_flag_ff, nmi_flag_in;
   logic [7:0]         led_ff, led_in;

   // Queue storage; the read data is registered from the slot at the tail pointer.
   logic [7:0]         key_mem [FIFO_DEPTH];
   logic [7:0]         mouse_mem [FIFO_DEPTH];
   logic [7:0]         key_rd_ff;
   logic [7:0]         mouse_rd_ff;
   logic               key_we;
   logic               mouse_we;
   logic [7:0]         key_wdata;
   logic [7:0]         mouse_wdata;

   logic signed [8:0]  dx;
   logic signed [8:0]  dy;
   logic [2:0]         psize;
   logic [CNT_W-1:0]   mouse_cnt;
   logic               key_empty;
   logic               mouse_empty;

   always_comb begin
      if (mx_ff > MOVE_MAX) begin
         dx = 9'(MOVE_MAX);
      end else if (mx_ff < MOVE_MIN) begin
         dx = 9'(MOVE_MIN);
      end else begin
         dx = mx_ff[8:0];
      end
      if (my_ff > MOVE_MAX) begin
         dy = 9'(MOVE_MAX);
      end else if (my_ff < MOVE_MIN) begin
         dy = 9'(MOVE_MIN);
      end else begin
         dy = my_ff[8:0];
      end
   end

   assign psize       = (mode_ff == MOUSE_ID_WHEEL) ? 3'd4 : 3'd3;
   assign mouse_cnt   = fifo_count(mouse_head_ff, mouse_tail_ff);
   assign key_empty   = (key_head_ff == key_tail_ff);
   assign mouse_empty = (mouse_head_ff == mouse_tail_ff);

   assign status.opcode       = op_ff;
   assign status.key_extended = ext_ff;
   assign status.packet4      = (mode_ff == MOUSE_ID_WHEEL);
   assign status.mouse_room   = mouse_cnt < (CNT_W'(FIFO_DEPTH) - CNT_W'(psize));
   // The remaining movement fits one packet when clamping leaves it unchanged.
   assign status.last_packet  = (mx_ff == 16'(dx)) && (my_ff == 16'(dy));

   always_comb begin
      unique case (cmd.mouse_sel)
         MB_FLAG:  mouse_wdata = {2'b00, dy[8], dx[8], 1'b1, btn_ff};
         MB_X:     mouse_wdata = dx[7:0];
         MB_Y:     mouse_wdata = dy[7:0];
         MB_WHEEL: mouse_wdata = wheel_ff;
         default:  mouse_wdata = wheel_ff;
      endcase
      if (cmd.key_prefix) begin
         key_wdata = down_ff ? KEY_PREFIX_PRESS : KEY_PREFIX_RELEASE;
      end else begin
         key_wdata = down_ff ? {1'b0, code_ff} : ({1'b0, code_ff} | KEY_RELEASE_BIT);
      end
   end

   always_comb begin
      op_in         = op_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      code_in       = code_ff;
      ext_in        = ext_ff;
      down_in       = down_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      btn_in        = btn_ff;
      wheel_in      = wheel_ff;
      rd_in         = rd_ff;
      pulse_in      = pulse_ff;
      rsp_in        = rsp_ff;
      key_head_in   = key_head_ff;
      key_tail_in   = key_tail_ff;
      mouse_head_in = mouse_head_ff;
      mouse_tail_in = mouse_tail_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      reset_flag_in = reset_flag_ff;
      nmi_flag_in   = nmi_flag_ff;
      led_in        = led_ff;
      key_we        = 1'b0;
      mouse_we      = 1'b0;

      if (cmd.load_item) begin
         op_in    = opcode_type'(req_tuser[1:0]);
         addr_in  = req_tdata[7:0];
         wdata_in = req_tdata[15:8];
         code_in  = req_tdata[22:16];
         ext_in   = req_tdata[23];
         down_in  = req_tdata[24];
         mx_in    = req_tdata[40:25];
         my_in    = req_tdata[56:41];
         btn_in   = req_tdata[59:57];
         wheel_in = req_tdata[67:60];
         rd_in    = '0;
         pulse_in = 1'b0;
      end

      if (cmd.exec_reg) begin
         if (op_ff == OP_READ) begin
            unique case (addr_ff)
               REG_KEY_DATA: begin
                  rd_in = '0;
                  if (!key_empty) begin
                     rd_in       = key_rd_ff;
                     key_tail_in = ptr_inc(key_tail_ff);
                  end
               end
               REG_MOUSE_DATA: begin
                  rd_in = '0;
                  if (pos_ff == 2'd0) begin
                     // A packet is handed out only once it is complete.
                     if (mouse_cnt >= CNT_W'(psize)) begin
                        pos_in        = 2'd1;
                        rd_in         = mouse_rd_ff;
                        mouse_tail_in = ptr_inc(mouse_tail_ff);
                     end
                  end else begin
                     pos_in = (({1'b0, pos_ff} + 3'd1) >= psize) ? 2'd0 : pos_ff + 2'd1;
                     if (!mouse_empty) begin
                        rd_in         = mouse_rd_ff;
                        mouse_tail_in = ptr_inc(mouse_tail_ff);
                     end
                  end
               end
               REG_MOUSE_ID: rd_in = {6'b0, mode_ff};
               default:      rd_in = REG_UNMAPPED;
            endcase
         end else begin
            unique case (addr_ff)
               REG_POWER: begin
                  if (wdata_ff == 8'd0) begin
                     pulse_in = 1'b1;
                  end else if (wdata_ff == 8'd1) begin
                     reset_flag_in = 1'b1;
                  end
               end
               REG_RESET: begin
                  if (wdata_ff == 8'd0) begin
                     reset_flag_in = 1'b1;
                  end
               end
               REG_NMI: begin
                  if (wdata_ff == 8'd0) begin
                     nmi_flag_in = 1'b1;
                  end
               end
               REG_LED: led_in = wdata_ff;
               REG_MOUSE_MODE: begin
                  if ((wdata_ff == 8'(MOUSE_ID_WHEEL)) || (wdata_ff == MOUSE_ID_ALIAS)) begin
                     mode_in = MOUSE_ID_WHEEL;
                  end else begin
                     mode_in = MOUSE_ID_BASIC;
                  end
                  mouse_head_in = '0;
                  mouse_tail_in = '0;
               end
               default: ;
            endcase
         end
      end

      if (cmd.key_push && (ptr_inc(key_head_ff) != key_tail_ff)) begin
         key_we      = 1'b1;
         key_head_in = ptr_inc(key_head_ff);
      end

      if (cmd.mouse_push && (ptr_inc(mouse_head_ff) != mouse_tail_ff)) begin
         mouse_we      = 1'b1;
         mouse_head_in = ptr_inc(mouse_head_ff);
      end

      if (cmd.mouse_advance) begin
         mx_in    = mx_ff - 16'(dx);
         my_in    = my_ff - 16'(dy);
         wheel_in = '0;
      end

      if (cmd.load_rsp) begin
         rsp_in = {5'b0, led_ff, pulse_ff, nmi_flag_ff, reset_flag_ff, rd_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_head_ff   <= '0;
         key_tail_ff   <= '0;
         mouse_head_ff <= '0;
         mouse_tail_ff <= '0;
         mode_ff       <= MOUSE_ID_WHEEL;
         pos_ff        <= 2'd0;
         reset_flag_ff <= 1'b0;
         nmi_flag_ff   <= 1'b0;
         led_ff        <= '0;
      end else begin
         key_head_ff   <= key_head_in;
         key_tail_ff   <= key_tail_in;
         mouse_head_ff <= mouse_head_in;
         mouse_tail_ff <= mouse_tail_in;
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         reset_flag_ff <= reset_flag_in;
         nmi_flag_ff   <= nmi_flag_in;
         led_ff        <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      code_ff  <= code_in;
      ext_ff   <= ext_in;
      down_ff  <= down_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      btn_ff   <= btn_in;
      wheel_ff <= wheel_in;
      rd_ff    <= rd_in;
      pulse_ff <= pulse_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_head_ff] <= key_wdata;
      end
      key_rd_ff <= key_mem[key_tail_ff];
   end

   always_ff @(posedge clock) begin
      if (mouse_we) begin
         mouse_mem[mouse_head_ff] <= mouse_wdata;
      end
      mouse_rd_ff <= mouse_mem[mouse_tail_ff];
   end

   assign rsp_tdata = rsp_ff;

endmodule

// ----- hw/rtl/keyboard_mouse_controller_registers.sv -----
// ----------------------------------------------------------------------------
// keyboard_mouse_controller_registers
// Keyboard and mouse system controller behind byte registers.
// ----------------------------------------------------------------------------
// Each transfer on the req channel is one item: a register read, a register
// write, a key event or a mouse event, selected by req_tuser. Every item gives
// exactly one transfer on the rsp channel with the read byte (zero for
// anything but a read), the sticky reset and NMI flags, the power-off pulse
// and the LED byte as they stand after the item.
// Items are handled one at a time. After acceptance, a register access is
// executed at dispatch and a key event pushes its byte, preceded by a prefix
// byte when extended. A mouse event runs a loop per packet: a room check,
// then one byte per cycle through the mouse queue write port (four bytes in
// mouse id 3, else three), or a dropped packet for lack of room; up to 129
// packets. The result is then loaded into the output register.
// The block takes the next item in the cycle after the result is loaded,
// while the result waits in the output register. If the receiver stalls, the
// next item's result is held back until the previous one has been taken, and
// no further item is taken.
// Reset empties both queues, clears the flags and the LED byte, and selects
// mouse id 3; queue contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module keyboard_mouse_controller_registers
   import kmcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // reg_addr, write_data, key_code, key_extended, key_down, move_x, move_y,
   // mouse_buttons, wheel_delta, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_data, reset_request, nmi_request, power_off_pulse, led_level,
   // zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   kmcr_cmd_type    cmd;
   kmcr_status_type status;

   kmcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   kmcr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ----- tb/sv/tb_keyboard_mouse_controller_registers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyboard_mouse_controller_registers
// Self-checking bench for the keyboard and mouse controller register block.
// ----------------------------------------------------------------------------
// A queue of register reads, register writes, key events and mouse events is
// built up front: a short directed part, then random groups such as a mouse
// event followed by packet reads, bursts of key events with key reads, and
// floods that overrun the key queue. A clocked driver offers the items on the
// req channel. Each accepted item runs through a local model of the queues,
// flags and mouse id, and the resulting status byte set is queued. A clocked
// monitor checks each rsp transfer, field by field, against the oldest one.
// Both sides idle in short random bursts; the receiver also holds off once
// for a long stretch, and the sender waits a few times for all results.
// ----------------------------------------------------------------------------
module tb_keyboard_mouse_controller_registers;
   import kmcr_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_LEFT   = 50;   // no idling once this few items remain
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AT_ITEM = 120;
   localparam int TAIL_CYCLES  = 20;

   // Values that trigger an action when written to the power, reset and NMI
   // registers.
   localparam logic [7:0] WR_TRIGGER     = 8'h00;
   localparam logic [7:0] WR_POWER_RESET = 8'h01;
   // An offset next to the LED register that writes must leave alone.
   localparam logic [7:0] REG_IGNORED    = 8'h04;

   typedef struct {
      opcode_type        op;
      logic [7:0]        addr;
      logic [7:0]        wdata;
      logic [6:0]        code;
      logic              ext;
      logic              down;
      logic signed [15:0] mx;
      logic signed [15:0] my;
      logic [2:0]        btn;
      logic [7:0]        wheel;
      bit                drain;
   } ctrl_item_type;

   typedef struct packed {
      logic [7:0] rd;
      logic       rst;
      logic       nmi;
      logic       pwr;
      logic [7:0] led;
   } status_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   ctrl_item_type item_q[$];
   status_type    pending_status[$];
   ctrl_item_type cur_item;
   bit         drain_req = 0;
   bit         req_fire = 0;
   int         req_gap = 0;
   int         rsp_hold = 0;
   bit         long_hold_done = 0;
   int         items_taken = 0;
   int         mismatches = 0;

   // Local copy of the controller state.
   logic [7:0]       kb_buf [FIFO_DEPTH];
   logic [PTR_W-1:0] kb_wr = '0;
   logic [PTR_W-1:0] kb_rd = '0;
   logic [7:0]       ms_buf [FIFO_DEPTH];
   logic [PTR_W-1:0] ms_wr = '0;
   logic [PTR_W-1:0] ms_rd = '0;
   logic [1:0]       id_now = MOUSE_ID_WHEEL;
   int               pkt_idx = 0;
   logic             rst_req = 1'b0;
   logic             nmi_req = 1'b0;
   logic [7:0]       led = 8'h00;

   keyboard_mouse_controller_registers u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Both rings keep one slot free, so a push into a full ring is lost.
   function automatic void kb_push(logic [7:0] v);
      if (PTR_W'(kb_wr + 1'b1) != kb_rd) begin
         kb_buf[kb_wr] = v;
         kb_wr = kb_wr + 1'b1;
      end
   endfunction

   function automatic void ms_push(logic [7:0] v);
      if (PTR_W'(ms_wr + 1'b1) != ms_rd) begin
         ms_buf[ms_wr] = v;
         ms_wr = ms_wr + 1'b1;
      end
   endfunction

   function automatic status_type next_status(ctrl_item_type it);
      status_type s;
      int      mx;
      int      my;
      int      dx;
      int      dy;
      int      size;
      logic [7:0] whl;
      s = '0;
      size = (id_now == MOUSE_ID_WHEEL) ? 4 : 3;
      case (it.op)
         OP_READ: begin
            case (it.addr)
               REG_KEY_DATA: begin
                  if (kb_wr != kb_rd) begin
                     s.rd = kb_buf[kb_rd];
                     kb_rd = kb_rd + 1'b1;
                  end
               end
               REG_MOUSE_DATA: begin
                  // A packet starts only once it is complete in the ring.
                  if (pkt_idx != 0 || int'(PTR_W'(ms_wr - ms_rd)) >= size) begin
                     if (pkt_idx == 0)
                        pkt_idx = 1;
                     else
                        pkt_idx = (pkt_idx + 1 >= size) ? 0 : pkt_idx + 1;
                     if (ms_wr != ms_rd) begin
                        s.rd = ms_buf[ms_rd];
                        ms_rd = ms_rd + 1'b1;
                     end
                  end
               end
               REG_MOUSE_ID: s.rd = {6'd0, id_now};
               default: s.rd = REG_UNMAPPED;
            endcase
         end
         OP_WRITE: begin
            case (it.addr)
               REG_POWER: begin
                  if (it.wdata == WR_TRIGGER)
                     s.pwr = 1'b1;
                  else if (it.wdata == WR_POWER_RESET)
                     rst_req = 1'b1;
               end
               REG_RESET: if (it.wdata == WR_TRIGGER) rst_req = 1'b1;
               REG_NMI: if (it.wdata == WR_TRIGGER) nmi_req = 1'b1;
               REG_LED: led = it.wdata;
               REG_MOUSE_MODE: begin
                  if (it.wdata == 8'(MOUSE_ID_BASIC) || it.wdata == 8'(MOUSE_ID_WHEEL))
                     id_now = it.wdata[1:0];
                  else if (it.wdata == MOUSE_ID_ALIAS)
                     id_now = MOUSE_ID_WHEEL;
                  else
                     id_now = MOUSE_ID_BASIC;
                  ms_wr = '0;
                  ms_rd = '0;
               end
               default: ;
            endcase
         end
         OP_KEY: begin
            if (it.ext)
               kb_push(it.down ? KEY_PREFIX_PRESS : KEY_PREFIX_RELEASE);
            kb_push(it.down ? {1'b0, it.code} : ({1'b0, it.code} | KEY_RELEASE_BIT));
         end
         default: begin
            mx = int'(it.mx);
            my = int'(it.my);
            whl = it.wheel;
            // At least one packet, then more until both moves are used up.
            do begin
               dx = (mx > 255) ? 255 : ((mx < -256) ? -256 : mx);
               dy = (my > 255) ? 255 : ((my < -256) ? -256 : my);
               if (int'(PTR_W'(ms_wr - ms_rd)) < FIFO_DEPTH - size) begin
                  ms_push({2'b00, dy < 0, dx < 0, 1'b1, it.btn});
                  ms_push(dx[7:0]);
                  ms_push(dy[7:0]);
                  if (size == 4)
                     ms_push(whl);
               end
               mx = mx - dx;
               my = my - dy;
               whl = 8'h00;
            end while (mx != 0 || my != 0);
         end
      endcase
      s.rst = rst_req;
      s.nmi = nmi_req;
      s.led = led;
      return s;
   endfunction

   // Stimulus builders. Fields that the opcode does not use carry random noise.
   function automatic ctrl_item_type noise_item();
      ctrl_item_type it;
      it.op    = opcode_type'($urandom_range(0, 3));
      it.addr  = 8'($urandom);
      it.wdata = 8'($urandom);
      it.code  = 7'($urandom);
      it.ext   = 1'($urandom);
      it.down  = 1'($urandom);
      it.mx    = 16'($urandom);
      it.my    = 16'($urandom);
      it.btn   = 3'($urandom);
      it.wheel = 8'($urandom);
      it.drain = 0;
      return it;
   endfunction

   function automatic void queue_item(ctrl_item_type it);
      it.drain = drain_req;
      drain_req = 0;
      item_q.push_back(it);
   endfunction

   function automatic void add_read(logic [7:0] a);
      ctrl_item_type it;
      it = noise_item();
      it.op = OP_READ;
      it.addr = a;
      queue_item(it);
   endfunction

   function automatic void add_write(logic [7:0] a, logic [7:0] v);
      ctrl_item_type it;
      it = noise_item();
      it.op = OP_WRITE;
      it.addr = a;
      it.wdata = v;
      queue_item(it);
   endfunction

   function automatic void add_key(logic [6:0] c, logic e, logic d);
      ctrl_item_type it;
      it = noise_item();
      it.op = OP_KEY;
      it.code = c;
      it.ext = e;
      it.down = d;
      queue_item(it);
   endfunction

   function automatic void add_mouse(logic signed [15:0] x, logic signed [15:0] y,
                                     logic [2:0] b, logic [7:0] w);
      ctrl_item_type it;
      it = noise_item();
      it.op = OP_MOUSE;
      it.mx = x;
      it.my = y;
      it.btn = b;
      it.wheel = w;
      queue_item(it);
   endfunction

   // Mostly small moves; now and then a clamp edge or a full-range move that
   // splits into many packets.
   function automatic logic signed [15:0] pick_move();
      case ($urandom_range(0, 19))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd255;
         3: return 16'sd256;
         4: return -16'sd256;
         5: return -16'sd257;
         6: return 16'sd0;
         7, 8: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 1200)) - 600);
      endcase
   endfunction

   function automatic logic [7:0] pick_value();
      case ($urandom_range(0, 7))
         0: return WR_TRIGGER;
         1: return WR_POWER_RESET;
         2: return 8'(MOUSE_ID_WHEEL);
         3: return MOUSE_ID_ALIAS;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // Sender: a new item goes out after a transfer or while the bus is idle.
   always @(negedge clock) begin : drive_req
      bit go;
      go = 0;
      if (!reset && (req_fire || !req_tvalid)) begin
         if (req_gap != 0)
            req_gap--;
         else if (item_q.size() != 0 &&
                  !(item_q[0].drain && pending_status.size() != 0))
            go = 1;
         if (go) begin
            cur_item = item_q.pop_front();
            req_tuser <= cur_item.op;
            req_tdata <= {4'd0, cur_item.wheel, cur_item.btn, cur_item.my, cur_item.mx,
                          cur_item.down, cur_item.ext, cur_item.code, cur_item.wdata,
                          cur_item.addr};
            if (item_q.size() >= QUIET_LEFT && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 5);
         end
         req_tvalid <= go;
      end
   end

   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         pending_status.push_back(next_status(cur_item));
         items_taken++;
      end
   end

   // Receiver: short random stalls, plus one long hold-off that backs the
   // block up until it stops taking items.
   always @(negedge clock) begin
      if (!reset) begin
         if (!long_hold_done && items_taken >= HOLD_AT_ITEM) begin
            long_hold_done = 1;
            rsp_hold = LONG_HOLD;
         end
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (item_q.size() >= QUIET_LEFT && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      status_type got;
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         // rsp_tdata: read_data, reset_request, nmi_request, power_off_pulse,
         // led_level from the lowest bit up.
         got = {rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[9], rsp_tdata[10],
                rsp_tdata[18:11]};
         if (pending_status.size() == 0) begin
            note_mismatch($sformatf("unexpected transfer %h", rsp_tdata));
         end else begin
            want = pending_status.pop_front();
            if (got.rd !== want.rd || got.rst !== want.rst || got.nmi !== want.nmi ||
                got.pwr !== want.pwr || got.led !== want.led)
               note_mismatch($sformatf(
                  "expected rd %h rst %b nmi %b pwr %b led %h, got rd %h rst %b nmi %b pwr %b led %h",
                  want.rd, want.rst, want.nmi, want.pwr, want.led,
                  got.rd, got.rst, got.nmi, got.pwr, got.led));
         end
      end
   end

   initial begin
      #100_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int groups;
      int total;
      logic [7:0] n;
      groups = 0;

      // Directed part: power-on values, empty reads, key prefixes, clamping
      // with a full mouse ring, and a mouse id change in the middle of a packet.
      add_read(REG_MOUSE_ID);
      add_read(REG_KEY_DATA);
      add_read(REG_MOUSE_DATA);
      add_read(8'hff);
      add_key(7'd0, 1'b0, 1'b1);
      add_key(7'h7f, 1'b1, 1'b0);
      add_key(7'h55, 1'b1, 1'b1);
      repeat (5) add_read(REG_KEY_DATA);
      add_mouse(16'sh7fff, 16'sh8000, 3'd7, 8'h80);
      repeat (5) add_read(REG_MOUSE_DATA);
      add_write(REG_MOUSE_MODE, MOUSE_ID_ALIAS);
      add_read(REG_MOUSE_DATA);
      add_write(REG_MOUSE_MODE, 8'h80);
      add_mouse(-16'sd1, 16'sd0, 3'd0, 8'h7f);
      repeat (3) add_read(REG_MOUSE_DATA);
      add_read(REG_MOUSE_ID);
      add_write(REG_POWER, WR_TRIGGER);
      add_write(REG_LED, 8'hff);
      add_write(REG_NMI, WR_TRIGGER);
      add_write(REG_MOUSE_MODE, 8'(MOUSE_ID_WHEEL));
      drain_req = 1;

      total = item_q.size() + RANDOM_ITEMS;
      while (item_q.size() < total) begin
         groups++;
         if (groups % 40 == 0)
            drain_req = 1;
         case ($urandom_range(0, 99)) inside
            [0:27]: begin
               add_mouse(pick_move(), pick_move(), 3'($urandom), 8'($urandom));
               repeat ($urandom_range(3, 9)) add_read(REG_MOUSE_DATA);
            end
            [28:47]: begin
               repeat ($urandom_range(1, 4))
                  add_key(7'($urandom), 1'($urandom), 1'($urandom));
               repeat ($urandom_range(0, 6)) add_read(REG_KEY_DATA);
            end
            [48:50]: repeat (20) add_key(7'($urandom), 1'($urandom), 1'($urandom));
            [51:62]: begin
               case ($urandom_range(0, 4))
                  0: n = REG_POWER;
                  1: n = REG_RESET;
                  2: n = REG_NMI;
                  3: n = REG_LED;
                  default: n = REG_IGNORED;
               endcase
               add_write(n, pick_value());
            end
            [63:65]: add_write(REG_MOUSE_MODE, pick_value());
            [66:71]: add_read(REG_MOUSE_ID);
            [72:80]: add_write(8'($urandom), 8'($urandom));
            [81:90]: add_read(8'($urandom));
            default: queue_item(noise_item());
         endcase
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (item_q.size() != 0 || req_tvalid || pending_status.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_status.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/kmcr_pkg.sv
hw/rtl/kmcr_ctrl.sv
hw/rtl/kmcr_dp.sv
hw/rtl/keyboard_mouse_controller_registers.sv
tb/sv/tb_keyboard_mouse_controller_registers.sv
